// ===== design/p2c_pkg.sv =====
// ----------------------------------------------------------------------------
// p2c_pkg
// Shared types, register codes, reset values and the divide-by-255 helpers of
// the palette index pipeline.
// ----------------------------------------------------------------------------
package p2c_pkg;

	localparam int NUM_STAGES = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int DIV_IN_W   = 17;
	localparam int DIV_Q_W    = 10;

	typedef enum logic [1:0] {
		MODE_GREY       = 2'd0,
		MODE_GREY_ALPHA = 2'd1,
		MODE_RGB        = 2'd2,
		MODE_RGBA       = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_MODE        = 3'd0,
		REG_CUBE_SIDE         = 3'd1,
		REG_RAMP_GREYS        = 3'd2,
		REG_GREY_BASE         = 3'd3,
		REG_BLACK_ENTRY       = 3'd4,
		REG_WHITE_ENTRY       = 3'd5,
		REG_TRANSPARENCY_ON   = 3'd6,
		REG_TRANSPARENT_ENTRY = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		mode_t      pixel_mode;
		logic [2:0] cube_side;
		logic [8:0] ramp_greys;
		logic [8:0] grey_base;
		logic [7:0] black_entry;
		logic [7:0] white_entry;
		logic       transparency_on;
		logic [7:0] transparent_entry;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		pixel_mode:        MODE_RGBA,
		cube_side:         3'd6,
		ramp_greys:        9'd39,
		grey_base:         9'd216,
		black_entry:       8'd0,
		white_entry:       8'd215,
		transparency_on:   1'b1,
		transparent_entry: 8'd255
	};

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] valid;
	} pipe_ctrl_t;

	// quotient estimate and remainder, the estimate is low by at most two
	typedef struct packed {
		logic [DIV_Q_W-1:0] q0;
		logic [9:0]         rem;
	} div_est_t;

	function automatic div_est_t div255_est(input logic [DIV_IN_W-1:0] x);
		logic [DIV_IN_W:0] num;
		logic [DIV_IN_W:0] diff;
		div_est_t          res;
		// x/255 is close to (x + x/256)/256 and never below it
		num     = {1'b0, x} + {9'b0, x[DIV_IN_W-1:8]};
		res.q0  = num[DIV_IN_W:8];
		diff    = {1'b0, x} - {res.q0, 8'b0} + {8'b0, res.q0};
		res.rem = diff[9:0];
		return res;
	endfunction

	function automatic logic [DIV_Q_W-1:0] div255_fix(input div_est_t e);
		logic [DIV_Q_W-1:0] q;
		if (e.rem >= 10'd510) begin
			q = e.q0 + 10'd2;
		end else if (e.rem >= 10'd255) begin
			q = e.q0 + 10'd1;
		end else begin
			q = e.q0;
		end
		return q;
	endfunction

endpackage

// ===== design/p2c_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// p2c_cfg_regs
// Configuration register bank, written one register per handshake.
// ----------------------------------------------------------------------------
module p2c_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [p2c_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [p2c_pkg::CFG_DATA_W-1:0]   cfg_data,
	output p2c_pkg::cfg_t                    cfg
);

	p2c_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= p2c_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (p2c_pkg::cfg_idx_t'(cfg_index))
				p2c_pkg::REG_PIXEL_MODE: begin
					cfg_q.pixel_mode <= p2c_pkg::mode_t'(cfg_data[1:0]);
				end
				p2c_pkg::REG_CUBE_SIDE:         cfg_q.cube_side         <= cfg_data[2:0];
				p2c_pkg::REG_RAMP_GREYS:        cfg_q.ramp_greys        <= cfg_data[8:0];
				p2c_pkg::REG_GREY_BASE:         cfg_q.grey_base         <= cfg_data[8:0];
				p2c_pkg::REG_BLACK_ENTRY:       cfg_q.black_entry       <= cfg_data[7:0];
				p2c_pkg::REG_WHITE_ENTRY:       cfg_q.white_entry       <= cfg_data[7:0];
				p2c_pkg::REG_TRANSPARENCY_ON:   cfg_q.transparency_on   <= cfg_data[0];
				p2c_pkg::REG_TRANSPARENT_ENTRY: cfg_q.transparent_entry <= cfg_data[7:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

endmodule

// ===== design/p2c_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// p2c_pipe_ctrl
// Valid bits and load enables of the pipeline stages; a stage loads when it
// is empty or when the stage after it moves on, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module p2c_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                out_stall,
	output p2c_pkg::pipe_ctrl_t ctrl
);

	localparam int N = p2c_pkg::NUM_STAGES;

	logic [N-1:0] valid_q;
	logic [N-1:0] adv;

	always_comb begin
		adv[N-1] = !valid_q[N-1] || !out_stall;
		for (int k = N - 2; k >= 0; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	assign in_stall   = !adv[0];
	assign ctrl.load  = adv;
	assign ctrl.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// a held item stays in its stage
	a_hold_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_q & ~adv) != '0) |=>
		((valid_q & $past(valid_q & ~adv)) == $past(valid_q & ~adv)))
		else $error("held pipeline item dropped");

	// input is only held off when every stage is full and the output is blocked
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> ((&valid_q) && out_stall))
		else $error("input stalled with room in pipeline");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_q[0])
		else $error("accepted item not in first stage");

endmodule

// ===== design/p2c_datapath.sv =====
// ----------------------------------------------------------------------------
// p2c_datapath
// Four register stages: operand products, divide-by-255 estimate,
// correction with first cube term, final index select.
// ----------------------------------------------------------------------------
module p2c_datapath (
	input  logic                clk,
	input  p2c_pkg::cfg_t       cfg,
	input  p2c_pkg::pipe_ctrl_t ctrl,
	input  logic [7:0]          red_or_grey,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic [7:0]          alpha,
	input  logic                row_end_in,
	output logic [7:0]          palette_index,
	output logic                row_end_out
);

	localparam int DW = p2c_pkg::DIV_IN_W;

	// stage 1 products
	logic [DW-1:0] ramp_x_s1;
	logic [10:0]   lr_x_s1;
	logic [10:0]   lg_x_s1;
	logic [10:0]   lb_x_s1;
	logic          grey_s1;
	logic          clear_s1;
	logic          row_end_s1;

	// stage 2 estimates
	p2c_pkg::div_est_t ramp_e_s2;
	p2c_pkg::div_est_t lr_e_s2;
	p2c_pkg::div_est_t lg_e_s2;
	p2c_pkg::div_est_t lb_e_s2;
	logic              grey_s2;
	logic              clear_s2;
	logic              row_end_s2;

	// stage 3 corrected terms
	logic [8:0] ramp_t_s3;
	logic [5:0] rg_s3;
	logic [2:0] lb_s3;
	logic       grey_s3;
	logic       clear_s3;
	logic       row_end_s3;

	// stage 4 output
	logic [7:0] palette_index_s4;
	logic       row_end_s4;

	logic [8:0] greys_m1;
	logic [2:0] side_m1;

	logic [p2c_pkg::DIV_Q_W-1:0] ramp_q;
	logic [p2c_pkg::DIV_Q_W-1:0] lr_q;
	logic [p2c_pkg::DIV_Q_W-1:0] lg_q;
	logic [p2c_pkg::DIV_Q_W-1:0] lb_q;
	logic [5:0]                  lr_side;

	logic [8:0] cube_full;
	logic [9:0] grey_sum;
	logic [7:0] grey_idx;
	logic [7:0] colour_idx;
	logic [7:0] ramp_idx;
	logic [7:0] idx_next;

	// zero greys or zero side makes the product, and so the term, zero
	assign greys_m1 = (cfg.ramp_greys == 9'd0) ? 9'd0 : cfg.ramp_greys - 9'd1;
	assign side_m1  = (cfg.cube_side == 3'd0) ? 3'd0 : cfg.cube_side - 3'd1;

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			ramp_x_s1  <= {9'b0, red_or_grey} * {8'b0, greys_m1};
			lr_x_s1    <= {3'b0, red_or_grey} * {8'b0, side_m1};
			lg_x_s1    <= {3'b0, green} * {8'b0, side_m1};
			lb_x_s1    <= {3'b0, blue} * {8'b0, side_m1};
			grey_s1    <= (red_or_grey == green) && (green == blue);
			clear_s1   <= alpha[7];
			row_end_s1 <= row_end_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			ramp_e_s2  <= p2c_pkg::div255_est(ramp_x_s1);
			lr_e_s2    <= p2c_pkg::div255_est({6'b0, lr_x_s1});
			lg_e_s2    <= p2c_pkg::div255_est({6'b0, lg_x_s1});
			lb_e_s2    <= p2c_pkg::div255_est({6'b0, lb_x_s1});
			grey_s2    <= grey_s1;
			clear_s2   <= clear_s1;
			row_end_s2 <= row_end_s1;
		end
	end

	assign ramp_q  = p2c_pkg::div255_fix(ramp_e_s2);
	assign lr_q    = p2c_pkg::div255_fix(lr_e_s2);
	assign lg_q    = p2c_pkg::div255_fix(lg_e_s2);
	assign lb_q    = p2c_pkg::div255_fix(lb_e_s2);
	assign lr_side = {3'b0, lr_q[2:0]} * {3'b0, cfg.cube_side};

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			ramp_t_s3  <= ramp_q[8:0];
			rg_s3      <= lr_side + {3'b0, lg_q[2:0]};
			lb_s3      <= lb_q[2:0];
			grey_s3    <= grey_s2;
			clear_s3   <= clear_s2;
			row_end_s3 <= row_end_s2;
		end
	end

	// grey in a cube mode: base + term - 1, clamped at the ends
	assign grey_sum = {1'b0, cfg.grey_base} + {1'b0, ramp_t_s3} - 10'd1;

	always_comb begin
		if (ramp_t_s3 == 9'd0) begin
			grey_idx = cfg.black_entry;
		end else if (ramp_t_s3 > cfg.ramp_greys) begin
			grey_idx = cfg.white_entry;
		end else begin
			grey_idx = grey_sum[7:0];
		end
	end

	assign cube_full  = {3'b0, rg_s3} * {6'b0, cfg.cube_side} + {6'b0, lb_s3};
	assign colour_idx = (grey_s3 && (cfg.ramp_greys != 9'd0)) ? grey_idx : cube_full[7:0];
	assign ramp_idx   = ramp_t_s3[7:0];

	always_comb begin
		case (cfg.pixel_mode)
			p2c_pkg::MODE_GREY: begin
				idx_next = ramp_idx;
			end
			p2c_pkg::MODE_GREY_ALPHA: begin
				idx_next = clear_s3 ? cfg.transparent_entry : ramp_idx;
			end
			p2c_pkg::MODE_RGB: begin
				idx_next = colour_idx;
			end
			default: begin
				idx_next = (clear_s3 && cfg.transparency_on) ? cfg.transparent_entry
				                                              : colour_idx;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			palette_index_s4 <= idx_next;
			row_end_s4       <= row_end_s3;
		end
	end

	assign palette_index = palette_index_s4;
	assign row_end_out   = row_end_s4;

endmodule

// ===== design/pixel_to_cube_palette_index_top.sv =====
// The block takes one pixel item per clock unless in_stall is high, and
// returns its palette index through four register stages (operand products,
// the divide-by-255 estimate, its correction with the first cube term, and
// the final index select). A blocked output stalls the input only once all
// four stages hold items. Configuration writes are accepted on every cycle
// and should be made while no item is in flight.
// ----------------------------------------------------------------------------
// pixel_to_cube_palette_index_top
// Maps 8-bit grey, grey+alpha, rgb or rgba pixels to a palette index of a
// uniform colour cube with a grey ramp and a transparent entry.
// ----------------------------------------------------------------------------
module pixel_to_cube_palette_index_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     red_or_grey,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	input  logic [7:0]                     alpha,
	input  logic                           row_end_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     palette_index,
	output logic                           row_end_out,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [p2c_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [p2c_pkg::CFG_DATA_W-1:0] cfg_data
);

	p2c_pkg::cfg_t       cfg;
	p2c_pkg::pipe_ctrl_t ctrl;

	p2c_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	p2c_pipe_ctrl u_pipe_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	p2c_datapath u_datapath (
		.clk           (clk),
		.cfg           (cfg),
		.ctrl          (ctrl),
		.red_or_grey   (red_or_grey),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.row_end_in    (row_end_in),
		.palette_index (palette_index),
		.row_end_out   (row_end_out)
	);

	assign out_valid = ctrl.valid[p2c_pkg::NUM_STAGES-1];

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel to palette index pipeline. A short table
// of hand-picked pixels and register writes is followed by phases of random
// pixels, each under a fresh register setting. Every result is compared, in
// order, with the table's result where given, else an in-bench model of the
// palette mapping; in most phases both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          STALL_LIMIT     = 2000;
	localparam int          SETTLE_CYCLES   = 2 * p2c_pkg::NUM_STAGES + 4;
	localparam int          NUM_PHASES      = 12;
	localparam int          PHASE_ITEMS     = 138;
	localparam int          PRESSURE_PHASE  = 5;
	localparam logic [7:0]  ALPHA_OPAQUE_MAX = 8'h7f;
	localparam int          DIR_ROWS        = 35;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       row_end;
	} pixel_t;

	typedef struct packed {
		logic       row_end;
		logic [7:0] index;
	} index_rec_t;

	// one row is either a register write or a pixel, optionally with its result
	typedef struct packed {
		logic              is_reg;
		p2c_pkg::cfg_idx_t ridx;
		logic [8:0]        rval;
		pixel_t            pix;
		logic              typed;
		logic [7:0]        want;
	} dir_row_t;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// reset setting: rgba cube, side 6, 39 greys from 216
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b1, 8'd0},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd255, 8'd255, 8'd255, 8'd0, 1'b1},
			1'b1, 8'd253},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd255, 8'd0, 8'd0, 8'd0, 1'b0},
			1'b1, 8'd180},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd0, 8'd255, 8'd0, 8'd127, 1'b0},
			1'b1, 8'd30},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd0, 8'd0, 8'd255, 8'd128, 1'b0},
			1'b1, 8'd255},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd255, 8'd255, 8'd0, 8'd255, 1'b1},
			1'b1, 8'd255},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd128, 8'd128, 8'd128, 8'd0, 1'b0},
			1'b0, 8'd0},
		'{1'b1, p2c_pkg::REG_TRANSPARENCY_ON, 9'd0, '0, 1'b0, 8'd0},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd0, 8'd0, 8'd255, 8'd200, 1'b0},
			1'b1, 8'd5},
		'{1'b1, p2c_pkg::REG_PIXEL_MODE, 9'(p2c_pkg::MODE_RGB), '0, 1'b0, 8'd0},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd255, 8'd0, 8'd255, 8'd255, 1'b0},
			1'b1, 8'd185},
		'{1'b1, p2c_pkg::REG_PIXEL_MODE, 9'(p2c_pkg::MODE_GREY_ALPHA), '0, 1'b0, 8'd0},
		// transparent even with transparency off
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd0, 8'd0, 8'd0, 8'd128, 1'b0},
			1'b1, 8'd255},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd255, 8'd17, 8'd99, 8'd0, 1'b1},
			1'b1, 8'd38},
		'{1'b1, p2c_pkg::REG_PIXEL_MODE, 9'(p2c_pkg::MODE_GREY), '0, 1'b0, 8'd0},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd255, 8'd0, 8'd0, 8'd255, 1'b0},
			1'b1, 8'd38},
		'{1'b1, p2c_pkg::REG_RAMP_GREYS, 9'd0, '0, 1'b0, 8'd0},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd200, 8'd3, 8'd4, 8'd0, 1'b0},
			1'b1, 8'd0},
		'{1'b1, p2c_pkg::REG_PIXEL_MODE, 9'(p2c_pkg::MODE_RGB), '0, 1'b0, 8'd0},
		// no ramp, so greys fall into the cube
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd255, 8'd255, 8'd255, 8'd0, 1'b0},
			1'b1, 8'd215},
		'{1'b1, p2c_pkg::REG_CUBE_SIDE, 9'd7, '0, 1'b0, 8'd0},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd255, 8'd255, 8'd255, 8'd0, 1'b0},
			1'b1, 8'd86},
		'{1'b1, p2c_pkg::REG_CUBE_SIDE, 9'd0, '0, 1'b0, 8'd0},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd255, 8'd0, 8'd17, 8'd0, 1'b1},
			1'b1, 8'd0},
		'{1'b1, p2c_pkg::REG_CUBE_SIDE, 9'd6, '0, 1'b0, 8'd0},
		'{1'b1, p2c_pkg::REG_RAMP_GREYS, 9'd256, '0, 1'b0, 8'd0},
		'{1'b1, p2c_pkg::REG_GREY_BASE, 9'd256, '0, 1'b0, 8'd0},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd255, 8'd255, 8'd255, 8'd0, 1'b0},
			1'b1, 8'd254},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd1, 8'd1, 8'd1, 8'd0, 1'b0}, 1'b0, 8'd0},
		'{1'b1, p2c_pkg::REG_BLACK_ENTRY, 9'd77, '0, 1'b0, 8'd0},
		'{1'b0, p2c_pkg::REG_PIXEL_MODE, 9'd0, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b1, 8'd77},
		'{1'b1, p2c_pkg::REG_WHITE_ENTRY, 9'd255, '0, 1'b0, 8'd0},
		'{1'b1, p2c_pkg::REG_TRANSPARENT_ENTRY, 9'd0, '0, 1'b0, 8'd0},
		'{1'b1, p2c_pkg::REG_PIXEL_MODE, 9'(p2c_pkg::MODE_RGBA), '0, 1'b0, 8'd0},
		'{1'b1, p2c_pkg::REG_TRANSPARENCY_ON, 9'd1, '0, 1'b0, 8'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  red_or_grey;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        row_end_in;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  palette_index;
	logic        row_end_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [p2c_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [p2c_pkg::CFG_DATA_W-1:0] cfg_data;

	p2c_pkg::cfg_t reg_shadow;
	index_rec_t    index_due [$];
	bit            calm;
	int            errors;
	int            items_sent;
	int            results_seen;
	int            writes_done;
	int            idle_cycles;

	pixel_to_cube_palette_index_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.red_or_grey   (red_or_grey),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.row_end_in    (row_end_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.palette_index (palette_index),
		.row_end_out   (row_end_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [7:0] palette_of(input p2c_pkg::cfg_t c, input pixel_t p);
		int  ri, gi, bi, n, side, base, ramp, v;
		bit  clear;
		ri    = p.r;
		gi    = p.g;
		bi    = p.b;
		n     = c.ramp_greys;
		side  = c.cube_side;
		base  = c.grey_base;
		clear = p.a > ALPHA_OPAQUE_MAX;
		ramp  = (n == 0) ? 0 : (ri * (n - 1)) / 255;
		case (c.pixel_mode)
			p2c_pkg::MODE_GREY: v = ramp;
			p2c_pkg::MODE_GREY_ALPHA: v = clear ? int'(c.transparent_entry) : ramp;
			default: begin
				if (c.pixel_mode == p2c_pkg::MODE_RGBA && clear && c.transparency_on) begin
					v = c.transparent_entry;
				end else if (ri == gi && gi == bi && n > 0) begin
					// ramp value held one above its palette slot
					v = base + ramp;
					if (v < base + 1)
						v = c.black_entry;
					else if (v >= base + n + 1)
						v = c.white_entry;
					else
						v = v - 1;
				end else if (side == 0) begin
					v = 0;
				end else begin
					v = (ri * (side - 1)) / 255;
					v = v * side + (gi * (side - 1)) / 255;
					v = v * side + (bi * (side - 1)) / 255;
				end
			end
		endcase
		return v[7:0];
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		int     sel;
		p.r = 8'($urandom);
		p.g = 8'($urandom);
		p.b = 8'($urandom);
		p.a = 8'($urandom);
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			p.g = p.r;
			p.b = p.r;
		end else if (sel == 4) begin
			p.r = {8{1'($urandom_range(0, 1))}};
			p.g = {8{1'($urandom_range(0, 1))}};
			p.b = {8{1'($urandom_range(0, 1))}};
		end
		// alpha right on either side of the threshold now and then
		case ($urandom_range(0, 5))
			0: p.a = ALPHA_OPAQUE_MAX;
			1: p.a = ALPHA_OPAQUE_MAX + 8'd1;
			default: ;
		endcase
		p.row_end = ($urandom_range(0, 7) == 0);
		return p;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic write_reg(input p2c_pkg::cfg_idx_t idx, input logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			p2c_pkg::REG_PIXEL_MODE:
				reg_shadow.pixel_mode = p2c_pkg::mode_t'(val[1:0]);
			p2c_pkg::REG_CUBE_SIDE:         reg_shadow.cube_side         = val[2:0];
			p2c_pkg::REG_RAMP_GREYS:        reg_shadow.ramp_greys        = val;
			p2c_pkg::REG_GREY_BASE:         reg_shadow.grey_base         = val;
			p2c_pkg::REG_BLACK_ENTRY:       reg_shadow.black_entry       = val[7:0];
			p2c_pkg::REG_WHITE_ENTRY:       reg_shadow.white_entry       = val[7:0];
			p2c_pkg::REG_TRANSPARENCY_ON:   reg_shadow.transparency_on   = val[0];
			p2c_pkg::REG_TRANSPARENT_ENTRY: reg_shadow.transparent_entry = val[7:0];
			default: ;
		endcase
		writes_done++;
	endtask

	// always waits on the clock so in_valid is never lowered and raised in one step
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (index_due.size() != 0);
	endtask

	task automatic push_pixel(input pixel_t p, input bit typed, input logic [7:0] want);
		int         gap;
		index_rec_t rec;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		red_or_grey <= p.r;
		green       <= p.g;
		blue        <= p.b;
		alpha       <= p.a;
		row_end_in  <= p.row_end;
		do @(posedge clk); while (in_stall);
		rec.index   = typed ? want : palette_of(reg_shadow, p);
		rec.row_end = p.row_end;
		index_due.push_back(rec);
		items_sent++;
	endtask

	// result side
	initial begin
		int         wait_n;
		index_rec_t rec;
		out_stall <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			wait_n = calm ? 0 : $urandom_range(0, 7);
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			results_seen++;
			if (index_due.size() == 0) begin
				report_mismatch("result with nothing due", palette_index, -1);
			end else begin
				rec = index_due.pop_front();
				if (palette_index !== rec.index)
					report_mismatch("palette_index", palette_index, rec.index);
				if (row_end_out !== rec.row_end)
					report_mismatch("row_end_out", row_end_out, rec.row_end);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [8:0] vals [8];
		bit         in_cfg;
		errors       = 0;
		items_sent   = 0;
		results_seen = 0;
		writes_done  = 0;
		calm         = 1'b0;
		in_cfg       = 1'b0;
		reg_shadow   = p2c_pkg::CFG_RESET;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		red_or_grey <= '0;
		green       <= '0;
		blue        <= '0;
		alpha       <= '0;
		row_end_in  <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].is_reg) begin
				if (!in_cfg)
					drain();
				write_reg(DIRECTED[i].ridx, DIRECTED[i].rval);
				in_cfg = 1'b1;
			end else begin
				if (in_cfg)
					cfg_valid <= 1'b0;
				in_cfg = 1'b0;
				push_pixel(DIRECTED[i].pix, DIRECTED[i].typed, DIRECTED[i].want);
			end
		end
		if (in_cfg)
			cfg_valid <= 1'b0;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			calm = (ph % 4 == 3);
			if (ph == 0) begin
				vals = '{9'(p2c_pkg::MODE_GREY), 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0};
			end else if (ph == 1) begin
				vals = '{9'(p2c_pkg::MODE_RGBA), 9'd7, 9'd256, 9'd256, 9'd255, 9'd255,
					9'd1, 9'd255};
			end else begin
				vals[p2c_pkg::REG_PIXEL_MODE] = 9'($urandom_range(0, 3));
				vals[p2c_pkg::REG_CUBE_SIDE]  = 9'($urandom_range(0, 7));
				case ($urandom_range(0, 4))
					0: vals[p2c_pkg::REG_RAMP_GREYS] = 9'd0;
					1: vals[p2c_pkg::REG_RAMP_GREYS] = 9'($urandom_range(1, 2));
					2: vals[p2c_pkg::REG_RAMP_GREYS] = 9'd256;
					default: vals[p2c_pkg::REG_RAMP_GREYS] = 9'($urandom_range(0, 256));
				endcase
				vals[p2c_pkg::REG_GREY_BASE]         = 9'($urandom_range(0, 256));
				vals[p2c_pkg::REG_BLACK_ENTRY]       = 9'($urandom_range(0, 255));
				vals[p2c_pkg::REG_WHITE_ENTRY]       = 9'($urandom_range(0, 255));
				vals[p2c_pkg::REG_TRANSPARENCY_ON]   = 9'($urandom_range(0, 1));
				vals[p2c_pkg::REG_TRANSPARENT_ENTRY] = 9'($urandom_range(0, 255));
			end
			for (int ri = 0; ri < 8; ri++)
				write_reg(p2c_pkg::cfg_idx_t'(ri), vals[ri]);
			cfg_valid <= 1'b0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// let the pipeline run dry mid-phase
				if (ph == PRESSURE_PHASE && k == PHASE_ITEMS / 2)
					drain();
				push_pixel(random_pixel(), 1'b0, 8'd0);
			end
		end

		drain();
		calm = 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (index_due.size() != 0)
			report_mismatch("results still due", 0, index_due.size());
		$display("ran %0d pixels through %0d register writes over %0d random settings",
			items_sent, writes_done, NUM_PHASES);
		$display("checked %0d results, %0d mismatches", results_seen, errors);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/p2c_pkg.sv
design/p2c_cfg_regs.sv
design/p2c_pipe_ctrl.sv
design/p2c_datapath.sv
design/pixel_to_cube_palette_index_top.sv
tb/sv/tb_top.sv
